>>> hdl/cle_pkg.sv
// cle_pkg: shared types, sizes and command codes of the cursor list engine
// used by cle_node_store and cursor_list_engine; depends on nothing else
`default_nettype none
package cle_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int VAL_W    = 32;

    localparam logic [3:0] CMD_CLEAR    = 4'd0;
    localparam logic [3:0] CMD_MFRONT   = 4'd1;
    localparam logic [3:0] CMD_MBACK    = 4'd2;
    localparam logic [3:0] CMD_MPREV    = 4'd3;
    localparam logic [3:0] CMD_MNEXT    = 4'd4;
    localparam logic [3:0] CMD_PREPEND  = 4'd5;
    localparam logic [3:0] CMD_APPEND   = 4'd6;
    localparam logic [3:0] CMD_INS_BEF  = 4'd7;
    localparam logic [3:0] CMD_INS_AFT  = 4'd8;
    localparam logic [3:0] CMD_DEL_FRNT = 4'd9;
    localparam logic [3:0] CMD_DEL_BACK = 4'd10;
    localparam logic [3:0] CMD_DEL_CUR  = 4'd11;
    localparam logic [3:0] CMD_QUERY    = 4'd12;

    typedef struct packed {
        logic [IDX_W-1:0] nxt;
        logic [IDX_W-1:0] prv;
    } t_link;

    typedef struct packed {
        logic             l_we;
        logic [IDX_W-1:0] l_waddr;
        t_link            l_wdata;
        logic [IDX_W-1:0] l_raddr;
        logic             v_we;
        logic [IDX_W-1:0] v_waddr;
        logic [VAL_W-1:0] v_wdata;
        logic [IDX_W-1:0] v_raddr;
    } t_store_req;

endpackage
`default_nettype wire

>>> hdl/cursor_list_engine.sv
// cursor_list_engine: doubly linked list of signed values with a cursor
// top level; uses cle_pkg and cle_node_store
//
// One command is taken at a time and runs through a short sequence of
// read-modify-write steps on the node link memory: a query, clear or
// front/back move needs no memory read, a prev/next move reads a link,
// then a value, and deletes and inserts take more steps, as the link
// memory has a single write port. Unused nodes are handed out from a fill
// count first and from a recycled free list after that, so no clearing
// pass follows reset. Front, back and cursor values are kept in registers.
`default_nettype none
module cursor_list_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [3:0]                    i_command,
    input  wire logic signed [cle_pkg::VAL_W-1:0] i_data_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_accepted,
    output logic [cle_pkg::CNT_W-1:0]          o_list_length,
    output logic signed [cle_pkg::CNT_W-1:0]   o_cursor_position,
    output logic signed [cle_pkg::VAL_W-1:0]   o_cursor_value,
    output logic signed [cle_pkg::VAL_W-1:0]   o_front_value,
    output logic signed [cle_pkg::VAL_W-1:0]   o_back_value
);

    localparam int IW = cle_pkg::IDX_W;
    localparam int CW = cle_pkg::CNT_W;
    localparam int VW = cle_pkg::VAL_W;

    localparam logic [2:0] S0     = 3'd0;
    localparam logic [2:0] S1     = 3'd1;
    localparam logic [2:0] S2     = 3'd2;
    localparam logic [2:0] S3     = 3'd3;
    localparam logic [2:0] S4     = 3'd4;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [CW-1:0] CIDX_NONE = '1;

    logic            r_busy, n_busy;
    logic [2:0]      r_step, n_step;
    logic [3:0]      r_cmd;
    logic [VW-1:0]   r_val;
    logic [IW-1:0]   r_head, n_head, r_tail, n_tail, r_cur, n_cur;
    logic [CW-1:0]   r_cidx, n_cidx, r_count, n_count, r_fresh, n_fresh;
    logic [IW-1:0]   r_freeh, n_freeh, r_n, n_n;
    cle_pkg::t_link  r_tmp, n_tmp;
    logic            r_from_free, n_from_free;
    logic            r_fh, n_fh, r_ft, n_ft, r_multi, n_multi, r_ok, n_ok;
    logic [VW-1:0]   r_front_v, n_front_v, r_back_v, n_back_v, r_cur_v, n_cur_v;

    cle_pkg::t_store_req req;
    cle_pkg::t_link      l_rd;
    logic [VW-1:0]       v_rd;

    logic          cur_def, empty, full, fresh_ok;
    logic [IW-1:0] del_node;

    cle_node_store u_store (
        .i_clk      (i_clk),
        .i_req      (req),
        .o_link_rd  (l_rd),
        .o_value_rd (v_rd)
    );

    assign cur_def  = !r_cidx[CW-1];
    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(cle_pkg::CAPACITY));
    assign fresh_ok = (r_fresh != CW'(cle_pkg::CAPACITY));
    assign o_ready  = !r_busy;

    always_comb begin
        unique case (r_cmd)
            cle_pkg::CMD_DEL_FRNT: del_node = r_head;
            cle_pkg::CMD_DEL_BACK: del_node = r_tail;
            default:               del_node = r_cur;
        endcase
    end

    always_comb begin
        n_busy = r_busy; n_step = r_step;
        n_head = r_head; n_tail = r_tail; n_cur = r_cur;
        n_cidx = r_cidx; n_count = r_count; n_fresh = r_fresh;
        n_freeh = r_freeh; n_n = r_n; n_tmp = r_tmp; n_from_free = r_from_free;
        n_fh = r_fh; n_ft = r_ft; n_multi = r_multi; n_ok = r_ok;
        n_front_v = r_front_v; n_back_v = r_back_v; n_cur_v = r_cur_v;
        req = '0;

        if (!r_busy) begin
            if (i_valid) begin
                n_busy = 1'b1;
                n_step = S0;
                n_ok   = 1'b1;
            end
        end else begin
            unique case (r_step)
                S0: begin
                    n_step = S_DONE;
                    priority case (r_cmd)
                        cle_pkg::CMD_CLEAR: begin
                            if (!empty) begin
                                req.l_we    = 1'b1;
                                req.l_waddr = r_tail;
                                req.l_wdata = '{nxt: r_freeh, prv: '0};
                                n_freeh     = r_head;
                            end
                            n_count = '0;
                            n_head  = '0;
                            n_tail  = '0;
                            n_cidx  = CIDX_NONE;
                            n_cur   = '0;
                        end
                        cle_pkg::CMD_MFRONT, cle_pkg::CMD_MBACK: begin
                            if (empty) begin
                                n_ok = 1'b0;
                            end else if (r_cmd == cle_pkg::CMD_MFRONT) begin
                                n_cur   = r_head;
                                n_cidx  = '0;
                                n_cur_v = r_front_v;
                            end else begin
                                n_cur   = r_tail;
                                n_cidx  = r_count - CW'(1);
                                n_cur_v = r_back_v;
                            end
                        end
                        cle_pkg::CMD_MPREV, cle_pkg::CMD_MNEXT: begin
                            if (!cur_def) begin
                                n_ok = 1'b0;
                            end else if ((r_cmd == cle_pkg::CMD_MPREV && r_cur == r_head) ||
                                         (r_cmd == cle_pkg::CMD_MNEXT && r_cur == r_tail)) begin
                                n_cidx = CIDX_NONE;
                                n_cur  = '0;
                            end else begin
                                req.l_raddr = r_cur;
                                n_step      = S1;
                            end
                        end
                        cle_pkg::CMD_PREPEND, cle_pkg::CMD_APPEND,
                        cle_pkg::CMD_INS_BEF, cle_pkg::CMD_INS_AFT: begin
                            if (full || (!cur_def && (r_cmd == cle_pkg::CMD_INS_BEF ||
                                                      r_cmd == cle_pkg::CMD_INS_AFT))) begin
                                n_ok = 1'b0;
                            end else begin
                                n_n         = fresh_ok ? r_fresh[IW-1:0] : r_freeh;
                                n_from_free = !fresh_ok;
                                if (fresh_ok) begin
                                    n_fresh = r_fresh + CW'(1);
                                end
                                req.l_raddr = r_freeh;
                                n_step      = S1;
                            end
                        end
                        cle_pkg::CMD_DEL_FRNT, cle_pkg::CMD_DEL_BACK,
                        cle_pkg::CMD_DEL_CUR: begin
                            if ((r_cmd == cle_pkg::CMD_DEL_CUR) ? !cur_def : empty) begin
                                n_ok = 1'b0;
                            end else begin
                                n_n         = del_node;
                                n_fh        = (del_node == r_head);
                                n_ft        = (del_node == r_tail);
                                n_multi     = (r_count > CW'(1));
                                req.l_raddr = del_node;
                                n_step      = S1;
                                if (r_cmd == cle_pkg::CMD_DEL_FRNT) begin
                                    if (cur_def) begin
                                        n_cidx = (r_cidx == '0) ? CIDX_NONE : r_cidx - CW'(1);
                                    end
                                end else if (r_cmd == cle_pkg::CMD_DEL_BACK) begin
                                    if (cur_def && r_cur == r_tail) begin
                                        n_cidx = CIDX_NONE;
                                    end
                                end else begin
                                    n_cidx = CIDX_NONE;
                                end
                            end
                        end
                        cle_pkg::CMD_QUERY: begin
                            n_ok = 1'b1;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
                S1: begin
                    n_step = S2;
                    priority case (r_cmd)
                        cle_pkg::CMD_MPREV, cle_pkg::CMD_MNEXT: begin
                            if (r_cmd == cle_pkg::CMD_MPREV) begin
                                n_cur       = l_rd.prv;
                                req.v_raddr = l_rd.prv;
                                n_cidx      = r_cidx - CW'(1);
                            end else begin
                                n_cur       = l_rd.nxt;
                                req.v_raddr = l_rd.nxt;
                                n_cidx      = r_cidx + CW'(1);
                            end
                        end
                        cle_pkg::CMD_DEL_FRNT, cle_pkg::CMD_DEL_BACK,
                        cle_pkg::CMD_DEL_CUR: begin
                            n_tmp       = l_rd;
                            req.l_we    = 1'b1;
                            req.l_waddr = r_n;
                            req.l_wdata = '{nxt: r_freeh, prv: '0};
                            n_freeh     = r_n;
                            n_count     = r_count - CW'(1);
                            if (!r_multi) begin
                                n_step = S_DONE;
                            end else if (r_fh) begin
                                n_head      = l_rd.nxt;
                                req.v_raddr = l_rd.nxt;
                            end else if (r_ft) begin
                                n_tail      = l_rd.prv;
                                req.v_raddr = l_rd.prv;
                            end else begin
                                req.l_raddr = l_rd.prv;
                            end
                        end
                        default: begin
                            if (r_from_free) begin
                                n_freeh = l_rd.nxt;
                            end
                            req.v_we    = 1'b1;
                            req.v_waddr = r_n;
                            req.v_wdata = r_val;
                            priority case (r_cmd)
                                cle_pkg::CMD_PREPEND: req.l_raddr = r_head;
                                cle_pkg::CMD_APPEND:  req.l_raddr = r_tail;
                                default:              req.l_raddr = r_cur;
                            endcase
                        end
                    endcase
                end
                S2: begin
                    n_step = S3;
                    priority case (r_cmd)
                        cle_pkg::CMD_MPREV, cle_pkg::CMD_MNEXT: begin
                            n_cur_v = v_rd;
                            n_step  = S_DONE;
                        end
                        cle_pkg::CMD_PREPEND, cle_pkg::CMD_APPEND: begin
                            if (empty) begin
                                n_head    = r_n;
                                n_tail    = r_n;
                                n_front_v = r_val;
                                n_back_v  = r_val;
                                n_count   = r_count + CW'(1);
                                n_step    = S_DONE;
                            end else if (r_cmd == cle_pkg::CMD_PREPEND) begin
                                req.l_we    = 1'b1;
                                req.l_waddr = r_head;
                                req.l_wdata = '{nxt: l_rd.nxt, prv: r_n};
                            end else begin
                                req.l_we    = 1'b1;
                                req.l_waddr = r_tail;
                                req.l_wdata = '{nxt: r_n, prv: l_rd.prv};
                            end
                        end
                        cle_pkg::CMD_INS_BEF: begin
                            n_tmp       = l_rd;
                            req.l_we    = 1'b1;
                            req.l_waddr = r_cur;
                            req.l_wdata = '{nxt: l_rd.nxt, prv: r_n};
                        end
                        cle_pkg::CMD_INS_AFT: begin
                            n_tmp       = l_rd;
                            req.l_we    = 1'b1;
                            req.l_waddr = r_cur;
                            req.l_wdata = '{nxt: r_n, prv: l_rd.prv};
                        end
                        default: begin
                            if (r_fh) begin
                                n_front_v = v_rd;
                                n_step    = S_DONE;
                            end else if (r_ft) begin
                                n_back_v = v_rd;
                                n_step   = S_DONE;
                            end else begin
                                req.l_we    = 1'b1;
                                req.l_waddr = r_tmp.prv;
                                req.l_wdata = '{nxt: r_tmp.nxt, prv: l_rd.prv};
                                req.l_raddr = r_tmp.nxt;
                            end
                        end
                    endcase
                end
                S3: begin
                    n_step  = S_DONE;
                    req.l_we = 1'b1;
                    priority case (r_cmd)
                        cle_pkg::CMD_PREPEND: begin
                            req.l_waddr = r_n;
                            req.l_wdata = '{nxt: r_head, prv: '0};
                            n_head      = r_n;
                            n_front_v   = r_val;
                            n_count     = r_count + CW'(1);
                            if (cur_def) begin
                                n_cidx = r_cidx + CW'(1);
                            end
                        end
                        cle_pkg::CMD_APPEND: begin
                            req.l_waddr = r_n;
                            req.l_wdata = '{nxt: '0, prv: r_tail};
                            n_tail      = r_n;
                            n_back_v    = r_val;
                            n_count     = r_count + CW'(1);
                        end
                        cle_pkg::CMD_INS_BEF: begin
                            req.l_waddr = r_n;
                            req.l_wdata = '{nxt: r_cur, prv: r_tmp.prv};
                            n_cidx      = r_cidx + CW'(1);
                            n_count     = r_count + CW'(1);
                            if (r_cur == r_head) begin
                                n_head    = r_n;
                                n_front_v = r_val;
                            end else begin
                                req.l_raddr = r_tmp.prv;
                                n_step      = S4;
                            end
                        end
                        cle_pkg::CMD_INS_AFT: begin
                            req.l_waddr = r_n;
                            req.l_wdata = '{nxt: r_tmp.nxt, prv: r_cur};
                            n_count     = r_count + CW'(1);
                            if (r_cur == r_tail) begin
                                n_tail   = r_n;
                                n_back_v = r_val;
                            end else begin
                                req.l_raddr = r_tmp.nxt;
                                n_step      = S4;
                            end
                        end
                        default: begin
                            req.l_waddr = r_tmp.nxt;
                            req.l_wdata = '{nxt: l_rd.nxt, prv: r_tmp.prv};
                        end
                    endcase
                end
                S4: begin
                    n_step   = S_DONE;
                    req.l_we = 1'b1;
                    if (r_cmd == cle_pkg::CMD_INS_BEF) begin
                        req.l_waddr = r_tmp.prv;
                        req.l_wdata = '{nxt: r_n, prv: l_rd.prv};
                    end else begin
                        req.l_waddr = r_tmp.nxt;
                        req.l_wdata = '{nxt: l_rd.nxt, prv: r_n};
                    end
                end
                default: begin
                    if (!o_valid || i_ready) begin
                        n_busy = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= S0;
            r_head  <= '0;
            r_tail  <= '0;
            r_cur   <= '0;
            r_cidx  <= CIDX_NONE;
            r_count <= '0;
            r_fresh <= '0;
            r_freeh <= '0;
            o_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_step  <= n_step;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cur   <= n_cur;
            r_cidx  <= n_cidx;
            r_count <= n_count;
            r_fresh <= n_fresh;
            r_freeh <= n_freeh;
            if (r_busy && r_step == S_DONE && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) begin
            r_cmd <= i_command;
            r_val <= i_data_value;
        end
        r_n         <= n_n;
        r_tmp       <= n_tmp;
        r_from_free <= n_from_free;
        r_fh        <= n_fh;
        r_ft        <= n_ft;
        r_multi     <= n_multi;
        r_ok        <= n_ok;
        r_front_v   <= n_front_v;
        r_back_v    <= n_back_v;
        r_cur_v     <= n_cur_v;
        if (r_busy && r_step == S_DONE && (!o_valid || i_ready)) begin
            o_accepted        <= r_ok;
            o_list_length     <= r_count;
            o_cursor_position <= r_cidx;
            o_cursor_value    <= cur_def ? r_cur_v : '0;
            o_front_value     <= empty ? '0 : r_front_v;
            o_back_value      <= empty ? '0 : r_back_v;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(cle_pkg::CAPACITY))
        else $error("element count above capacity");

    a_empty_no_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_list_length == '0) |-> (o_cursor_position == CIDX_NONE))
        else $error("cursor defined on an empty list");

    a_cursor_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && cur_def) |-> (r_cidx < r_count))
        else $error("cursor index beyond list length");

endmodule
`default_nettype wire

>>> hdl/cle_node_store.sv
// cle_node_store: link memory and value memory of the list nodes
// one write and one registered read per memory and cycle; uses cle_pkg
`default_nettype none
module cle_node_store (
    input  wire logic                        i_clk,
    input  wire cle_pkg::t_store_req         i_req,
    output cle_pkg::t_link                   o_link_rd,
    output logic [cle_pkg::VAL_W-1:0]        o_value_rd
);

    cle_pkg::t_link             links  [cle_pkg::CAPACITY];
    logic [cle_pkg::VAL_W-1:0]  values [cle_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.l_we) begin
            links[i_req.l_waddr] <= i_req.l_wdata;
        end
        o_link_rd <= links[i_req.l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.v_we) begin
            values[i_req.v_waddr] <= i_req.v_wdata;
        end
        o_value_rd <= values[i_req.v_raddr];
    end

endmodule
`default_nettype wire

>>> bench/tb_cursor_list_engine.sv
// tb_cursor_list_engine: self-checking bench for the cursor list engine
// directed table then random command streams, checked against a list predictor
// depends on cle_pkg and cursor_list_engine
`default_nettype none
module tb_cursor_list_engine;

    typedef struct packed {
        logic             acc;
        logic [8:0]       len;
        logic [8:0]       cpos;
        logic [31:0]      cval;
        logic [31:0]      fval;
        logic [31:0]      bval;
    } t_snap;

    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] val;
        logic        typed;
        logic        acc;
        int          len;
        int          cpos;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_command;
    logic signed [31:0] i_data_value;
    logic        o_valid;
    logic        i_ready;
    logic        o_accepted;
    logic [8:0]  o_list_length;
    logic signed [8:0]  o_cursor_position;
    logic signed [31:0] o_cursor_value;
    logic signed [31:0] o_front_value;
    logic signed [31:0] o_back_value;

    cursor_list_engine u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .i_data_value(i_data_value), .o_valid(o_valid),
        .i_ready(i_ready), .o_accepted(o_accepted), .o_list_length(o_list_length),
        .o_cursor_position(o_cursor_position), .o_cursor_value(o_cursor_value),
        .o_front_value(o_front_value), .o_back_value(o_back_value)
    );

    // predictor state: list kept as a plain array of values
    logic [31:0] list_vals[$];
    int          cur_idx;
    t_snap       snap_q[$];
    int          errors;
    longint      cycles;
    int          long_rx;

    function automatic t_snap predict_list(logic [3:0] cmd, logic [31:0] v);
        t_snap s;
        logic  ok;
        int    n;
        ok = 1'b1;
        n  = list_vals.size();
        case (cmd)
            cle_pkg::CMD_CLEAR: begin
                list_vals.delete();
                cur_idx = -1;
            end
            cle_pkg::CMD_MFRONT: if (n == 0) ok = 1'b0; else cur_idx = 0;
            cle_pkg::CMD_MBACK:  if (n == 0) ok = 1'b0; else cur_idx = n - 1;
            cle_pkg::CMD_MPREV:  if (cur_idx < 0) ok = 1'b0; else cur_idx = cur_idx - 1;
            cle_pkg::CMD_MNEXT: begin
                if (cur_idx < 0) ok = 1'b0;
                else if (cur_idx == n - 1) cur_idx = -1;
                else cur_idx = cur_idx + 1;
            end
            cle_pkg::CMD_PREPEND: begin
                if (n >= cle_pkg::CAPACITY) ok = 1'b0;
                else begin
                    list_vals.push_front(v);
                    if (cur_idx >= 0) cur_idx = cur_idx + 1;
                end
            end
            cle_pkg::CMD_APPEND: begin
                if (n >= cle_pkg::CAPACITY) ok = 1'b0;
                else list_vals.push_back(v);
            end
            cle_pkg::CMD_INS_BEF: begin
                if (n >= cle_pkg::CAPACITY || cur_idx < 0) ok = 1'b0;
                else begin
                    list_vals.insert(cur_idx, v);
                    cur_idx = cur_idx + 1;
                end
            end
            cle_pkg::CMD_INS_AFT: begin
                if (n >= cle_pkg::CAPACITY || cur_idx < 0) ok = 1'b0;
                else list_vals.insert(cur_idx + 1, v);
            end
            cle_pkg::CMD_DEL_FRNT: begin
                if (n == 0) ok = 1'b0;
                else begin
                    if (cur_idx >= 0) cur_idx = cur_idx - 1;
                    void'(list_vals.pop_front());
                end
            end
            cle_pkg::CMD_DEL_BACK: begin
                if (n == 0) ok = 1'b0;
                else begin
                    if (cur_idx == n - 1) cur_idx = -1;
                    void'(list_vals.pop_back());
                end
            end
            cle_pkg::CMD_DEL_CUR: begin
                if (cur_idx < 0) ok = 1'b0;
                else begin
                    list_vals.delete(cur_idx);
                    cur_idx = -1;
                end
            end
            cle_pkg::CMD_QUERY: ;
            default: ok = 1'b0;
        endcase
        n      = list_vals.size();
        s.acc  = ok;
        s.len  = n[8:0];
        s.cpos = cur_idx[8:0];
        s.cval = (cur_idx >= 0) ? list_vals[cur_idx] : 32'd0;
        s.fval = (n > 0) ? list_vals[0] : 32'd0;
        s.bval = (n > 0) ? list_vals[n-1] : 32'd0;
        return s;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles = cycles + 1;
            if (cycles > 1000000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: random stalls and comparison
    initial begin
        t_snap got;
        t_snap want;
        int    g;
        i_ready = 1'b0;
        long_rx = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            g = (long_rx > 0) ? 0 : gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got = {o_accepted, o_list_length, o_cursor_position, o_cursor_value,
                   o_front_value, o_back_value};
            if (snap_q.size() == 0) begin
                $display("%0t unexpected transfer: actual %h", $time, got);
                errors = errors + 1;
            end else begin
                want = snap_q.pop_front();
                if (got.acc !== want.acc)
                    $display("%0t accepted: expected %0d actual %0d", $time, want.acc, got.acc);
                if (got.len !== want.len)
                    $display("%0t list_length: expected %0d actual %0d", $time, want.len, got.len);
                if (got.cpos !== want.cpos)
                    $display("%0t cursor_position: expected %0d actual %0d", $time,
                             $signed(want.cpos), $signed(got.cpos));
                if (got.cval !== want.cval)
                    $display("%0t cursor_value: expected %h actual %h", $time, want.cval, got.cval);
                if (got.fval !== want.fval)
                    $display("%0t front_value: expected %h actual %h", $time, want.fval, got.fval);
                if (got.bval !== want.bval)
                    $display("%0t back_value: expected %h actual %h", $time, want.bval, got.bval);
                if (got !== want) errors = errors + 1;
            end
        end
    end

    t_row dir_rows[$];

    task automatic add_row(logic [3:0] c, logic [31:0] v, int t, int a, int l, int p);
        t_row r;
        r.cmd = c; r.val = v; r.typed = (t != 0); r.acc = (a != 0); r.len = l; r.cpos = p;
        dir_rows.push_back(r);
    endtask

    task automatic send_cmd(logic [3:0] c, logic [31:0] v, logic nogap);
        int g;
        g = nogap ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= c;
        i_data_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        snap_q.push_back(predict_list(c, v));
    endtask

    initial begin
        int    k;
        int    mode;
        int    r;
        logic [3:0]  c;
        logic [31:0] v;
        errors       = 0;
        cur_idx      = -1;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_command    = cle_pkg::CMD_QUERY;
        i_data_value = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-list rejections, extremes of values, every command
        add_row(cle_pkg::CMD_QUERY,    32'd0,        1, 1, 0, -1);
        add_row(cle_pkg::CMD_MFRONT,   32'd0,        1, 0, 0, -1);
        add_row(cle_pkg::CMD_MBACK,    32'd0,        1, 0, 0, -1);
        add_row(cle_pkg::CMD_MPREV,    32'd0,        1, 0, 0, -1);
        add_row(cle_pkg::CMD_MNEXT,    32'd0,        1, 0, 0, -1);
        add_row(cle_pkg::CMD_DEL_FRNT, 32'd0,        1, 0, 0, -1);
        add_row(cle_pkg::CMD_DEL_BACK, 32'd0,        1, 0, 0, -1);
        add_row(cle_pkg::CMD_DEL_CUR,  32'd0,        1, 0, 0, -1);
        add_row(cle_pkg::CMD_INS_BEF,  32'd5,        1, 0, 0, -1);
        add_row(cle_pkg::CMD_INS_AFT,  32'd5,        1, 0, 0, -1);
        add_row(4'd13,                 32'd0,        1, 0, 0, -1);
        add_row(4'd15,                 32'hffffffff, 1, 0, 0, -1);
        add_row(cle_pkg::CMD_APPEND,   32'h7fffffff, 1, 1, 1, -1);
        add_row(cle_pkg::CMD_PREPEND,  32'h80000000, 1, 1, 2, -1);
        add_row(cle_pkg::CMD_MFRONT,   32'd0,        1, 1, 2, 0);
        add_row(cle_pkg::CMD_MPREV,    32'd0,        1, 1, 2, -1);
        add_row(cle_pkg::CMD_MBACK,    32'd0,        1, 1, 2, 1);
        add_row(cle_pkg::CMD_INS_BEF,  32'hffffffff, 0, 0, 0, 0);
        add_row(cle_pkg::CMD_INS_AFT,  32'h00000001, 0, 0, 0, 0);
        add_row(cle_pkg::CMD_MNEXT,    32'd0,        0, 0, 0, 0);
        add_row(cle_pkg::CMD_MNEXT,    32'd0,        0, 0, 0, 0);
        add_row(cle_pkg::CMD_DEL_CUR,  32'd0,        0, 0, 0, 0);
        add_row(cle_pkg::CMD_DEL_FRNT, 32'd0,        0, 0, 0, 0);
        add_row(cle_pkg::CMD_CLEAR,    32'd0,        1, 1, 0, -1);
        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].cmd, dir_rows[i].val, 1'b0);
            if (dir_rows[i].typed && (snap_q[$].acc !== dir_rows[i].acc ||
                snap_q[$].len !== dir_rows[i].len[8:0] ||
                snap_q[$].cpos !== dir_rows[i].cpos[8:0])) begin
                $display("%0t directed row %0d: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                         $time, i, dir_rows[i].acc, dir_rows[i].len, dir_rows[i].cpos,
                         snap_q[$].acc, snap_q[$].len, $signed(snap_q[$].cpos));
                errors = errors + 1;
            end
        end

        // fill the store to capacity, probe the full case, drain, then random
        for (k = 0; k < cle_pkg::CAPACITY + 2; k++)
            send_cmd(cle_pkg::CMD_APPEND, $urandom, 1'b1);
        send_cmd(cle_pkg::CMD_MFRONT, 0, 1'b0);
        send_cmd(cle_pkg::CMD_INS_BEF, $urandom, 1'b0);
        send_cmd(cle_pkg::CMD_INS_AFT, $urandom, 1'b0);
        send_cmd(cle_pkg::CMD_PREPEND, $urandom, 1'b0);
        send_cmd(cle_pkg::CMD_DEL_CUR, 0, 1'b0);
        send_cmd(cle_pkg::CMD_PREPEND, $urandom, 1'b0);
        send_cmd(cle_pkg::CMD_CLEAR, 0, 1'b0);

        for (k = 0; k < 1600; k++) begin
            mode = (k / 200) % 3;
            r = $urandom_range(0, 99);
            if (r < 3) c = cle_pkg::CMD_CLEAR;
            else if (r < 6) c = 4'($urandom_range(13, 15));
            else if (r < 40 + mode * 8) c = 4'($urandom_range(5, 8));
            else if (r < 72) c = 4'($urandom_range(1, 4));
            else if (r < 94) c = 4'($urandom_range(9, 11));
            else c = cle_pkg::CMD_QUERY;
            r = $urandom_range(0, 9);
            v = (r == 0) ? 32'h80000000 : (r == 1) ? 32'h7fffffff : $urandom;
            long_rx = ($urandom_range(0, 19) == 0) ? 1 : 0;
            send_cmd(c, v, $urandom_range(0, 3) == 0);
        end
        i_valid <= 1'b0;

        while (snap_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
